>>> rtl/core/cwg_pkg.sv
// ----------------------------------------------------------------------------
// cwg_pkg: shared constants for the context window generator
// Default sizes, the fixed width of the column field and the reset window.
// ----------------------------------------------------------------------------
package cwg_pkg;

	localparam int MAX_WINDOW_DEF = 4;
	localparam int ID_BITS_DEF    = 24;
	localparam int COL_BITS       = 4;
	localparam int WIN_BITS       = 3;

	localparam logic [WIN_BITS-1:0] WINDOW_RESET = 3'd2;

endpackage

>>> rtl/core/context_window_generator.sv
// ----------------------------------------------------------------------------
// context_window_generator: context rows over regions of token ids
// Turns a token stream into rows of 2W+1 context cells, one cell per item.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : token_id, region_end; region_end marks the last token of
//                 a region. One token is taken at a time.
//   out channel : one cell per item: cell_id (-1 outside the region), column,
//                 row_last on the last cell of a row, run_last on the last
//                 cell caused by the token.
//   cfg channel : window size, always ready; above MAX_WINDOW it saturates.
//   A token that completes a row is emitted cell by cell: a single cell
//   sequencer walks the columns and reads the history line once per cell.
//   A region end flushes up to W+1 rows. A token that completes no row
//   emits nothing and leaves the block ready. The first cell passes through
//   the state register and the output register before it turns valid.
//   Reset clears the region count and sets the window to 2; history needs
//   no clearing. When the receiver stalls, the cell waiting in the output
//   register holds and the sequencer holds with it.
// ----------------------------------------------------------------------------
module context_window_generator #(
	parameter int MAX_WINDOW = cwg_pkg::MAX_WINDOW_DEF,
	parameter int ID_BITS    = cwg_pkg::ID_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cwg_pkg::WIN_BITS-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ID_BITS-1:0]              token_id,
	input  logic                            region_end,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [ID_BITS:0]         cell_id,
	output logic [cwg_pkg::COL_BITS-1:0]    column,
	output logic                            row_last,
	output logic                            run_last
);
	import cwg_pkg::*;

	localparam int DEPTH = 2 * MAX_WINDOW + 1;
	localparam int IW    = $clog2(DEPTH);
	localparam int PW    = $clog2(DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic                state_q;
	logic [WIN_BITS-1:0] window_q;
	logic [PW-1:0]       pos_q;
	logic [PW-1:0]       w_q;
	logic [PW-1:0]       back_q;
	logic [PW-1:0]       col_q;
	logic                end_q;

	logic                out_valid_q;
	logic [ID_BITS:0]    cell_q;
	logic [COL_BITS-1:0] column_q;
	logic                row_last_q;
	logic                run_last_q;

	logic                in_acc;
	logic                emit;
	logic [PW-1:0]       w_eff;
	logic [PW-1:0]       pos_inc;
	logic [PW-1:0]       pos_dec;
	logic [PW-1:0]       sum;
	logic [PW-1:0]       off;
	logic                cell_ok;
	logic                is_row_last;
	logic                is_run_last;
	logic [ID_BITS-1:0]  rd_data;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign emit      = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	assign w_eff   = (window_q > WIN_BITS'(MAX_WINDOW)) ? PW'(MAX_WINDOW) : PW'(window_q);
	assign pos_inc = (pos_q < PW'(DEPTH)) ? pos_q + PW'(1) : pos_q;
	assign pos_dec = pos_inc - PW'(1);

	assign sum         = back_q + w_q;
	assign off         = sum - col_q;
	assign cell_ok     = (sum >= col_q) && (off < pos_q);
	assign is_row_last = (col_q == PW'(2 * w_q));
	assign is_run_last = is_row_last && (!end_q || back_q == '0);

	cwg_hist #(
		.DEPTH   (DEPTH),
		.ID_BITS (ID_BITS)
	) u_hist (
		.clk      (clk),
		.shift_en (in_acc),
		.din      (token_id),
		.rd_idx   (off[IW-1:0]),
		.rd_data  (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			w_q     <= '0;
			back_q  <= '0;
			col_q   <= '0;
			end_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pos_q <= pos_inc;
						w_q   <= w_eff;
						col_q <= '0;
						end_q <= region_end;
						if (region_end) begin
							back_q  <= (pos_dec < w_eff) ? pos_dec : w_eff;
							state_q <= ST_EMIT;
						end else if (pos_inc > w_eff) begin
							back_q  <= w_eff;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (emit) begin
						if (is_run_last) begin
							state_q <= ST_IDLE;
							if (end_q) begin
								pos_q <= '0;
							end
						end else if (is_row_last) begin
							back_q <= back_q - PW'(1);
							col_q  <= '0;
						end else begin
							col_q <= col_q + PW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the cell while the receiver stalls
	always_ff @(posedge clk) begin
		if (emit) begin
			cell_q     <= cell_ok ? {1'b0, rd_data} : '1;
			column_q   <= COL_BITS'(col_q);
			row_last_q <= is_row_last;
			run_last_q <= is_run_last;
		end
	end

	assign out_valid = out_valid_q;
	assign cell_id   = $signed(cell_q);
	assign column    = column_q;
	assign row_last  = row_last_q;
	assign run_last  = run_last_q;

endmodule

>>> rtl/core/cwg_hist.sv
// ----------------------------------------------------------------------------
// cwg_hist: token history shift line
// Holds the newest DEPTH token ids, newest at entry 0, with one read port.
// ----------------------------------------------------------------------------
module cwg_hist #(
	parameter int DEPTH   = 2 * cwg_pkg::MAX_WINDOW_DEF + 1,
	parameter int ID_BITS = cwg_pkg::ID_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       shift_en,
	input  logic [ID_BITS-1:0]         din,
	input  logic [$clog2(DEPTH)-1:0]   rd_idx,
	output logic [ID_BITS-1:0]         rd_data
);
	import cwg_pkg::*;

	logic [ID_BITS-1:0] hist_q [DEPTH];

	// advance on every accepted item
	always_ff @(posedge clk) begin
		if (shift_en) begin
			hist_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	assign rd_data = hist_q[rd_idx];

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the context window generator
// Streams regions of token ids into the block and checks every cell that
// comes out against rows predicted in the bench. Covers the window extremes,
// a saturated window, window changes within a region, short and long regions,
// back pressure, and randomized regions under several idling mixes.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAXW       = cwg_pkg::MAX_WINDOW_DEF;
	localparam int ID_W       = cwg_pkg::ID_BITS_DEF;
	localparam int HIST_DEPTH = 2 * MAXW + 1;
	localparam int SETTLE     = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_LEN   = 300;

	typedef struct {
		logic signed [ID_W:0]          cell_val;
		logic [cwg_pkg::COL_BITS-1:0]  col;
		logic                          row_last;
		logic                          run_last;
	} cell_exp_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [cwg_pkg::WIN_BITS-1:0]  cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [ID_W-1:0]               token_id;
	logic                          region_end;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [ID_W:0]          cell_id;
	logic [cwg_pkg::COL_BITS-1:0]  column;
	logic                          row_last;
	logic                          run_last;

	cell_exp_t                     expected_cells[$];
	cell_exp_t                     cell_want;
	logic [ID_W-1:0]               token_hist[HIST_DEPTH];
	int                            region_count = 0;
	logic [cwg_pkg::WIN_BITS-1:0]  window_setting = cwg_pkg::WINDOW_RESET;

	int mismatches     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;
	int region_left    = 0;

	context_window_generator #(
		.MAX_WINDOW(MAXW),
		.ID_BITS(ID_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.token_id(token_id),
		.region_end(region_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cell_id(cell_id),
		.column(column),
		.row_last(row_last),
		.run_last(run_last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < 20)
			$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	// Queue the cells of the row centered 'back' tokens before the newest one.
	task automatic push_row(input int back, input int w);
		int j;
		int off;
		cell_exp_t c;
		for (j = 0; j <= 2 * w; j++) begin
			off = back + w - j;
			if (off >= 0 && off < region_count && off < HIST_DEPTH)
				c.cell_val = {1'b0, token_hist[off]};
			else
				c.cell_val = '1;
			c.col = cwg_pkg::COL_BITS'(j);
			c.row_last = (j == 2 * w);
			c.run_last = 1'b0;
			expected_cells.push_back(c);
		end
	endtask

	task automatic predict_rows(input logic [ID_W-1:0] id, input logic last);
		int w;
		int k;
		int i;
		int n_before;
		w = (window_setting > MAXW) ? MAXW : int'(window_setting);
		for (i = HIST_DEPTH - 1; i > 0; i--)
			token_hist[i] = token_hist[i - 1];
		token_hist[0] = id;
		if (region_count < HIST_DEPTH)
			region_count++;
		n_before = expected_cells.size();
		if (last) begin
			k = (region_count - 1 < w) ? region_count - 1 : w;
			for (; k >= 0; k--)
				push_row(k, w);
			region_count = 0;
		end else if (region_count > w) begin
			push_row(w, w);
		end
		if (expected_cells.size() > n_before)
			expected_cells[expected_cells.size() - 1].run_last = 1'b1;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_cells.size() == 0) begin
					report_mismatch("cell with nothing expected", cell_id, 0);
				end else begin
					cell_want = expected_cells.pop_front();
					if (cell_id !== cell_want.cell_val)
						report_mismatch("cell_id", cell_id, cell_want.cell_val);
					if (column !== cell_want.col)
						report_mismatch("column", column, cell_want.col);
					if (row_last !== cell_want.row_last)
						report_mismatch("row_last", row_last, cell_want.row_last);
					if (run_last !== cell_want.run_last)
						report_mismatch("run_last", run_last, cell_want.run_last);
				end
			end
			if (in_valid && in_ready)
				predict_rows(token_id, region_end);
			if (cfg_valid && cfg_ready)
				window_setting = cfg_data;
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic logic [ID_W-1:0] pick_id();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return ID_W'($urandom);
		endcase
	endfunction

	task automatic send_token(input logic [ID_W-1:0] id, input logic last);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		token_id <= id;
		region_end <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold the sender until every expected cell is out and the block settles.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_window(input logic [cwg_pkg::WIN_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_tokens(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			if (region_left == 0)
				region_left = ($urandom_range(7) == 0) ? $urandom_range(9, 20)
					: $urandom_range(1, 8);
			send_token(pick_id(), region_left == 1);
			region_left--;
		end
	endtask

	task automatic test_default_window();
		send_token(24'h000000, 1'b0);
		send_token(24'hFFFFFF, 1'b0);
		send_token(24'h555555, 1'b0);
		send_token(24'hAAAAAA, 1'b1);
	endtask

	task automatic test_short_regions();
		send_token(24'h0F0F0F, 1'b1);
		send_token(24'hF0F0F0, 1'b0);
		send_token(24'h00FFFF, 1'b1);
	endtask

	task automatic test_window_zero();
		drain_results();
		write_window(3'd0);
		send_token(24'h123456, 1'b0);
		send_token(24'hEDCBA9, 1'b1);
	endtask

	task automatic test_oversized_window();
		int i;
		drain_results();
		write_window(3'd7);
		for (i = 0; i < 10; i++)
			send_token(pick_id(), i == 9);
	endtask

	task automatic test_window_change();
		drain_results();
		write_window(3'd1);
		send_token(pick_id(), 1'b0);
		send_token(pick_id(), 1'b0);
		send_token(pick_id(), 1'b0);
		drain_results();
		write_window(3'd4);
		send_token(pick_id(), 1'b0);
		send_token(pick_id(), 1'b1);
	endtask

	task automatic test_backpressure();
		int i;
		drain_results();
		write_window(3'd4);
		hold_left = HOLD_LEN;
		for (i = 0; i < 15; i++)
			send_token(pick_id(), i == 14);
		drain_results();
	endtask

	task automatic run_phase(input int s_pct, input int r_pct,
		input logic [cwg_pkg::WIN_BITS-1:0] win_a,
		input logic [cwg_pkg::WIN_BITS-1:0] win_b, input int n);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		drain_results();
		write_window(win_a);
		send_random_tokens(n / 2);
		drain_results();
		write_window(win_b);
		send_random_tokens(n - n / 2);
		while (region_left != 0)
			send_random_tokens(1);
	endtask

	task automatic test_random_phases();
		run_phase(0, 0, 3'd3, 3'd5, 58);
		run_phase(45, 0, 3'd1, 3'd4, 58);
		run_phase(0, 45, 3'd6, 3'd0, 58);
		run_phase(13, 13, 3'd2, 3'd7, 58);
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		token_id = '0;
		region_end = 1'b0;
		out_ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_window();
		test_short_regions();
		test_window_zero();
		test_oversized_window();
		test_window_change();
		test_backpressure();
		test_random_phases();
		drain_results();

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/cwg_pkg.sv
rtl/core/cwg_hist.sv
rtl/core/context_window_generator.sv
sim/tb_top.sv
